>>> design/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and character helpers for the character stream
// tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

    // Default accumulator width for decimal literals
    localparam int VALUE_WIDTH_DEF = 32;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Result kinds
    localparam logic [2:0] KIND_END   = 3'd0;
    localparam logic [2:0] KIND_OP    = 3'd1;
    localparam logic [2:0] KIND_ICHAR = 3'd2;
    localparam logic [2:0] KIND_IEND  = 3'd3;
    localparam logic [2:0] KIND_INT   = 3'd4;
    localparam logic [2:0] KIND_ERR   = 3'd5;

    // Operator codes
    localparam logic [3:0] OP_AND    = 4'd0;
    localparam logic [3:0] OP_LT     = 4'd1;
    localparam logic [3:0] OP_GT     = 4'd2;
    localparam logic [3:0] OP_PLUS   = 4'd3;
    localparam logic [3:0] OP_MINUS  = 4'd4;
    localparam logic [3:0] OP_TIMES  = 4'd5;
    localparam logic [3:0] OP_DIV    = 4'd6;
    localparam logic [3:0] OP_EQ     = 4'd7;
    localparam logic [3:0] OP_ASSIGN = 4'd8;
    localparam logic [3:0] OP_NE     = 4'd9;
    localparam logic [3:0] OP_NOT    = 4'd10;

    // Scanner modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_AMP    = 3'd1;
    localparam logic [2:0] MODE_EQ     = 3'd2;
    localparam logic [2:0] MODE_BANG   = 3'd3;
    localparam logic [2:0] MODE_IDENT  = 3'd4;
    localparam logic [2:0] MODE_NUMBER = 3'd5;
    localparam logic [2:0] MODE_HALT   = 3'd6;

    // Operator characters
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  op_code;
        logic [7:0]  ident_char;
        logic [31:0] int_value;
        logic        last;
    } cst_result_t;

    // Up to two results produced by one scan step
    typedef struct packed {
        logic [1:0]  count;
        cst_result_t first;
        cst_result_t second;
    } cst_step_t;

    function automatic cst_result_t make_result(
        input logic [2:0]  kind,
        input logic [3:0]  op_code,
        input logic [7:0]  ident_char,
        input logic [31:0] int_value
    );
        cst_result_t r;
        r.kind       = kind;
        r.op_code    = op_code;
        r.ident_char = ident_char;
        r.int_value  = int_value;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

>>> design/char_stream_tokenizer_top.sv
// ----------------------------------------------------------------------------
// char_stream_tokenizer_top
// Lexical scanner over a character stream: operators, identifiers streamed
// per character, saturating decimal integers, end and error results.
// ----------------------------------------------------------------------------
// Path: a character passes through the input register, then one scan step
//   into the four-entry result queue; the step waits for two free entries.
// Throughput: one character per cycle while the queue has room; a character
//   with two results needs two output transfers; the queue holds the extra one.
// Reset: synchronous active-low aresetn clears the scanner to idle, the
//   accumulator to zero and empties the input register and result queue.
// ----------------------------------------------------------------------------
module char_stream_tokenizer_top import cst_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [3:0]  m_op_code,
    output logic [7:0]  m_ident_char,
    output logic [31:0] m_int_value,
    output logic        m_last
);

    logic        in_valid_reg;
    logic [7:0]  ch_reg;
    logic        eoi_reg;
    logic        room;
    logic        step_go;
    cst_step_t   step;
    cst_result_t out_res;

    assign step_go = in_valid_reg && room;
    assign s_ready = !in_valid_reg || step_go;

    // Hold the accepted character until the queue has room for its results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg  <= s_ch;
            eoi_reg <= s_end_of_input;
        end
    end

    cst_scan #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_go),
        .ch           (ch_reg),
        .end_of_input (eoi_reg),
        .step         (step)
    );

    cst_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step),
        .push_en   (step_go),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_kind       = out_res.kind;
    assign m_op_code    = out_res.op_code;
    assign m_ident_char = out_res.ident_char;
    assign m_int_value  = out_res.int_value;
    assign m_last       = out_res.last;

endmodule

>>> design/cst_scan.sv
// ----------------------------------------------------------------------------
// cst_scan
// Scanner state and single-step token logic: one character in, up to two
// results out, mode and number accumulator updated on each step.
// ----------------------------------------------------------------------------
module cst_scan import cst_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  logic [7:0]      ch,
    input  logic            end_of_input,
    output cst_step_t       step
);

    logic [2:0]             mode_reg, mode_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;

    logic [VALUE_WIDTH+3:0] acc_wide;
    logic [VALUE_WIDTH+3:0] acc_mul;
    logic [VALUE_WIDTH+31:0] acc_ext;
    logic [31:0]            acc_low;
    logic [3:0]             digit;

    // Multiply-add by ten for the next decimal digit
    assign digit    = ch[3:0];
    assign acc_wide = {4'b0, acc_reg};
    assign acc_mul  = (acc_wide << 3) + (acc_wide << 1)
                    + {{VALUE_WIDTH{1'b0}}, digit};
    assign acc_ext  = {32'b0, acc_reg};
    assign acc_low  = acc_ext[31:0];

    // Resolve the pending token, then scan the character from idle
    always_comb begin
        logic        lead_valid;
        logic        tail_valid;
        logic        pending;
        cst_result_t lead_res;
        cst_result_t tail_res;

        lead_valid = 1'b0;
        tail_valid = 1'b0;
        pending    = 1'b1;
        lead_res   = make_result(KIND_END, 4'd0, 8'd0, 32'd0);
        tail_res   = make_result(KIND_END, 4'd0, 8'd0, 32'd0);
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        step       = '0;

        case (mode_reg)
            MODE_HALT: begin
                pending = 1'b0;
            end
            MODE_AMP: begin
                lead_valid = 1'b1;
                pending    = 1'b0;
                if (!end_of_input && ch == CH_AMP) begin
                    lead_res  = make_result(KIND_OP, OP_AND, 8'd0, 32'd0);
                    mode_next = MODE_IDLE;
                end else begin
                    lead_res  = make_result(KIND_ERR, 4'd0, 8'd0, 32'd0);
                    mode_next = MODE_HALT;
                end
            end
            MODE_EQ: begin
                lead_valid = 1'b1;
                mode_next  = MODE_IDLE;
                if (!end_of_input && ch == CH_EQ) begin
                    lead_res = make_result(KIND_OP, OP_EQ, 8'd0, 32'd0);
                    pending  = 1'b0;
                end else begin
                    lead_res = make_result(KIND_OP, OP_ASSIGN, 8'd0, 32'd0);
                end
            end
            MODE_BANG: begin
                lead_valid = 1'b1;
                mode_next  = MODE_IDLE;
                if (!end_of_input && ch == CH_EQ) begin
                    lead_res = make_result(KIND_OP, OP_NE, 8'd0, 32'd0);
                    pending  = 1'b0;
                end else begin
                    lead_res = make_result(KIND_OP, OP_NOT, 8'd0, 32'd0);
                end
            end
            MODE_IDENT: begin
                lead_valid = 1'b1;
                if (!end_of_input && (is_alpha(ch) || is_digit(ch))) begin
                    lead_res = make_result(KIND_ICHAR, 4'd0, ch, 32'd0);
                    pending  = 1'b0;
                end else begin
                    lead_res  = make_result(KIND_IEND, 4'd0, 8'd0, 32'd0);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUMBER: begin
                if (!end_of_input && is_digit(ch)) begin
                    pending = 1'b0;
                    // Saturate once the value leaves the accumulator range
                    if (acc_mul[VALUE_WIDTH+3:VALUE_WIDTH] != 4'd0) begin
                        acc_next = '1;
                    end else begin
                        acc_next = acc_mul[VALUE_WIDTH-1:0];
                    end
                end else begin
                    lead_valid = 1'b1;
                    lead_res   = make_result(KIND_INT, 4'd0, 8'd0, acc_low);
                    acc_next   = '0;
                    mode_next  = MODE_IDLE;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        // Scan the character from idle
        if (pending) begin
            if (end_of_input) begin
                tail_valid = 1'b1;
                tail_res   = make_result(KIND_END, 4'd0, 8'd0, 32'd0);
                mode_next  = MODE_IDLE;
            end else if (is_space(ch)) begin
                tail_valid = 1'b0;
            end else begin
                case (ch)
                    CH_AMP:   mode_next = MODE_AMP;
                    CH_EQ:    mode_next = MODE_EQ;
                    CH_BANG:  mode_next = MODE_BANG;
                    CH_LT: begin
                        tail_valid = 1'b1;
                        tail_res   = make_result(KIND_OP, OP_LT, 8'd0, 32'd0);
                    end
                    CH_GT: begin
                        tail_valid = 1'b1;
                        tail_res   = make_result(KIND_OP, OP_GT, 8'd0, 32'd0);
                    end
                    CH_PLUS: begin
                        tail_valid = 1'b1;
                        tail_res   = make_result(KIND_OP, OP_PLUS, 8'd0, 32'd0);
                    end
                    CH_MINUS: begin
                        tail_valid = 1'b1;
                        tail_res   = make_result(KIND_OP, OP_MINUS, 8'd0, 32'd0);
                    end
                    CH_STAR: begin
                        tail_valid = 1'b1;
                        tail_res   = make_result(KIND_OP, OP_TIMES, 8'd0, 32'd0);
                    end
                    CH_SLASH: begin
                        tail_valid = 1'b1;
                        tail_res   = make_result(KIND_OP, OP_DIV, 8'd0, 32'd0);
                    end
                    default: begin
                        if (is_alpha(ch)) begin
                            tail_valid = 1'b1;
                            tail_res   = make_result(KIND_ICHAR, 4'd0, ch, 32'd0);
                            mode_next  = MODE_IDENT;
                        end else if (is_digit(ch)) begin
                            acc_next  = {{(VALUE_WIDTH-4){1'b0}}, digit};
                            mode_next = MODE_NUMBER;
                        end else begin
                            tail_valid = 1'b1;
                            tail_res   = make_result(KIND_ERR, 4'd0, 8'd0, 32'd0);
                            mode_next  = MODE_HALT;
                        end
                    end
                endcase
            end
        end

        // Pack results in order and flag the final one
        if (lead_valid) begin
            step.first  = lead_res;
            step.second = tail_res;
            step.count  = tail_valid ? 2'd2 : 2'd1;
        end else begin
            step.first  = tail_res;
            step.count  = tail_valid ? 2'd1 : 2'd0;
        end
        if (step.count == 2'd2) begin
            step.second.last = 1'b1;
        end else if (step.count == 2'd1) begin
            step.first.last = 1'b1;
        end
    end

    // Advance scanner state on each step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
        end else if (step_en) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

    // Halt holds until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_HALT) |=> (mode_reg == MODE_HALT))
        else $error("scanner left halt without reset");

    // Halted scanner produces nothing
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_HALT) |-> (step.count == 2'd0))
        else $error("halted scanner produced a result");

endmodule

>>> design/cst_result_fifo.sv
// ----------------------------------------------------------------------------
// cst_result_fifo
// Small result queue: takes zero, one or two results per cycle and hands
// them out one per transfer.
// ----------------------------------------------------------------------------
module cst_result_fifo import cst_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cst_step_t   push,
    input  logic        push_en,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output cst_result_t out_res
);

    cst_result_t             mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic [1:0]              push_cnt;
    logic                    pop;
    logic [FIFO_PTR_W-1:0]   wr_ptr_inc;

    assign push_cnt   = push_en ? push.count : 2'd0;
    assign pop        = out_valid && out_ready;
    assign room       = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign out_res    = mem[rd_ptr_reg];
    assign wr_ptr_inc = wr_ptr_reg + FIFO_PTR_W'(1);

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store results in order
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_inc] <= push.second;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt != 2'd0) |-> room)
        else $error("push without room");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push_cnt == 2'd0) |=> (count_reg == $past(count_reg) - FIFO_CNT_W'(1)))
        else $error("occupancy did not drop on transfer");

endmodule
